@@ rtl/triangular_index_to_row_col_core_macros.svh @@
// Assertion macros for the triangular index unrank core.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef TRIANGULAR_INDEX_TO_ROW_COL_CORE_MACROS_SVH
`define TRIANGULAR_INDEX_TO_ROW_COL_CORE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define TRI_RC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tri_rc: check failed");

// Next-cycle implication, held off during reset.
`define TRI_RC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tri_rc: check failed");

`endif

@@ rtl/tri_rc_pkg.sv @@
// Shared types and fixed widths of the triangular index unrank core.
// No dependencies.
package tri_rc_pkg;

  localparam int unsigned IDX_W = 32;
  localparam int unsigned OUT_W = 16;
  localparam int unsigned CFG_W = 16;

  // Side information that travels with each item down the chain.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             oor;
  } meta_t;

endpackage

@@ rtl/tri_rc_sqrt_cell.sv @@
// One digit step of the pipelined integer square root.
// Depends on tri_rc_pkg for the item side information.
module tri_rc_sqrt_cell #(
  parameter int unsigned SW = 36,
  parameter int unsigned RW = 18
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tri_rc_pkg::meta_t   meta_i,
  input  logic [SW-1:0]       rad_i,
  input  logic [RW+2:0]       rem_i,
  input  logic [RW-1:0]       root_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tri_rc_pkg::meta_t   meta_o,
  output logic [SW-1:0]       rad_o,
  output logic [RW+2:0]       rem_o,
  output logic [RW-1:0]       root_o
);
  import tri_rc_pkg::*;

  localparam int unsigned RMW = RW + 3;

  logic            valid_q;
  logic            en;
  meta_t           meta_q;
  logic [SW-1:0]   rad_q;
  logic [RMW-1:0]  rem_q, rem_d, rem_sh, trial;
  logic [RW-1:0]   root_q, root_d;

  assign en         = !valid_q || out_ready_i;
  assign in_ready_o = en;

  // Bring down the next pair of radicand bits and try the next root bit.
  assign rem_sh = {rem_i[RMW-3:0], rad_i[SW-1:SW-2]};
  assign trial  = RMW'({root_i, 2'b01});

  always_comb begin
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_i[RW-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_i[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      meta_q <= meta_i;
      rad_q  <= {rad_i[SW-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign out_valid_o = valid_q;
  assign meta_o      = meta_q;
  assign rad_o       = rad_q;
  assign rem_o       = rem_q;
  assign root_o      = root_q;

endmodule

@@ rtl/tri_rc_finish.sv @@
// Turns the square root into row and column: three registered stages.
// Depends on tri_rc_pkg for widths and the item side information.
module tri_rc_finish #(
  parameter int unsigned NW = 16,
  parameter int unsigned RW = 18
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [NW-1:0]             size_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  tri_rc_pkg::meta_t         meta_i,
  input  logic [RW+2:0]             rem_i,
  input  logic [RW-1:0]             root_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [tri_rc_pkg::OUT_W-1:0] row_o,
  output logic [tri_rc_pkg::OUT_W-1:0] col_o,
  output logic                      oor_o
);
  import tri_rc_pkg::*;

  localparam int unsigned PW = 2 * NW + 1;
  localparam int unsigned CW = (2 * NW > IDX_W) ? 2 * NW : IDX_W;

  logic             v1_q, v2_q, v3_q;
  logic             en1, en2, en3;
  meta_t            m1_q, m2_q;
  logic [NW-1:0]    row1_q, row2_q;
  logic [PW-2:0]    tri2_q, nrow2_q;
  logic [OUT_W-1:0] row3_q, col3_q;
  logic             oor3_q;

  logic [RW-1:0]    half, k;
  logic [NW-1:0]    row_d;
  logic [PW-1:0]    tri_prod;
  logic [PW-2:0]    nrow_prod;
  logic [CW-1:0]    col_full;

  assign en3        = !v3_q || !out_stall_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // An exact root means a is itself triangular: step k down by one.
  assign half  = (root_i - RW'(1)) >> 1;
  assign k     = half - RW'(rem_i == '0);
  assign row_d = size_i - k[NW-1:0] - NW'(1);

  assign tri_prod  = PW'(row1_q) * PW'({1'b0, row1_q} + (NW + 1)'(1));
  assign nrow_prod = (PW - 1)'(size_i) * (PW - 1)'(row1_q);

  assign col_full = CW'(m2_q.idx) + CW'(tri2_q) - CW'(nrow2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      m1_q   <= meta_i;
      row1_q <= row_d;
    end
    if (en2 && v1_q) begin
      m2_q    <= m1_q;
      row2_q  <= row1_q;
      tri2_q  <= tri_prod[PW-1:1];
      nrow2_q <= nrow_prod;
    end
    if (en3 && v2_q) begin
      oor3_q <= m2_q.oor;
      row3_q <= m2_q.oor ? '0 : OUT_W'(row2_q);
      col3_q <= m2_q.oor ? '0 : col_full[OUT_W-1:0];
    end
  end

  assign out_valid_o = v3_q;
  assign row_o       = row3_q;
  assign col_o       = col3_q;
  assign oor_o       = oor3_q;

endmodule

@@ rtl/triangular_index_to_row_col_core.sv @@
// Top level of the triangular index unrank core.
// Depends on tri_rc_pkg, tri_rc_sqrt_cell, tri_rc_finish and the macros header.
//
// Maps a flat index into the row-major upper triangle (diagonal included)
// of an n by n matrix back to its row and column.
// Channels: input items (flat_index_i) on in_valid_i / in_stall_o, result
// items (row_index_o, col_index_o, out_of_range_o) on out_valid_o /
// out_stall_i. An item moves at an edge with valid high and stall low.
// Configuration: cfg_we_i writes n from cfg_wdata_i; write only while idle.
// Stages: one range-check stage, one square-root cell per root bit
// (SIZE_BITS' + 2 cells, where SIZE_BITS' is SIZE_BITS capped at 16), and
// three stages for row and column.
// Throughput: one item per cycle unless the receiver stalls; the root cells set the latency.
// Out-of-range indices flow through the same chain and come out flagged
// with row and column zero.
// Reset clears all valid bits and sets n to 1.
// When the receiver stalls, the output holds and bubbles inside the chain
// still close up; in_stall_o rises only once every stage is full.
`include "triangular_index_to_row_col_core_macros.svh"

module triangular_index_to_row_col_core #(
  parameter int unsigned SIZE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tri_rc_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [tri_rc_pkg::IDX_W-1:0]        flat_index_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tri_rc_pkg::OUT_W-1:0]        row_index_o,
  output logic [tri_rc_pkg::OUT_W-1:0]        col_index_o,
  output logic                                out_of_range_o
);
  import tri_rc_pkg::*;

  // Kept width of n, triangle total, radicand and root.
  localparam int unsigned NW = (SIZE_BITS < CFG_W) ? SIZE_BITS : CFG_W;
  localparam int unsigned TW = 2 * NW;
  localparam int unsigned SW = TW + 4;
  localparam int unsigned RW = SW / 2;
  localparam int unsigned CW = (TW > IDX_W) ? TW : IDX_W;

  // Configuration: n and its triangle total, formed once at write time.
  logic [NW-1:0] size_q, size_d;
  logic [TW-1:0] total_q, total_d;
  logic [TW:0]   cfg_prod;

  assign size_d   = cfg_wdata_i[NW-1:0];
  assign cfg_prod = (TW + 1)'(size_d) * (TW + 1)'({1'b0, size_d} + (NW + 1)'(1));
  assign total_d  = cfg_prod[TW:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= NW'(1);
      total_q <= TW'(1);
    end else if (cfg_we_i) begin
      size_q  <= size_d;
      total_q <= total_d;
    end
  end

  // Front stage: range check and radicand 8a+1.
  logic          fv_q, fen;
  meta_t         fm_q;
  logic [SW-1:0] frad_q;
  logic          oor_d;
  logic [CW-1:0] diff;

  logic          cv   [RW+1];
  logic          crdy [RW+1];
  meta_t         cm   [RW+1];
  logic [SW-1:0] crad [RW+1];
  logic [RW+2:0] crem [RW+1];
  logic [RW-1:0] croot[RW+1];

  assign oor_d      = CW'(flat_index_i) >= CW'(total_q);
  assign diff       = CW'(total_q) - CW'(flat_index_i);
  assign fen        = !fv_q || crdy[0];
  assign in_stall_o = !fen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (fen) begin
      fv_q <= in_valid_i;
    end
  end

  // Drop the radicand to zero for out-of-range items; their root is unused.
  always_ff @(posedge clk_i) begin
    if (fen && in_valid_i) begin
      fm_q.idx <= flat_index_i;
      fm_q.oor <= oor_d;
      frad_q   <= oor_d ? '0 : {1'b0, diff[TW-1:0], 3'b001};
    end
  end

  assign cv[0]    = fv_q;
  assign cm[0]    = fm_q;
  assign crad[0]  = frad_q;
  assign crem[0]  = '0;
  assign croot[0] = '0;

  // Root chain: one result bit per cell, most significant first.
  for (genvar i = 0; i < RW; i++) begin : g_cell
    tri_rc_sqrt_cell #(
      .SW (SW),
      .RW (RW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (cv[i]),
      .in_ready_o  (crdy[i]),
      .meta_i      (cm[i]),
      .rad_i       (crad[i]),
      .rem_i       (crem[i]),
      .root_i      (croot[i]),
      .out_valid_o (cv[i+1]),
      .out_ready_i (crdy[i+1]),
      .meta_o      (cm[i+1]),
      .rad_o       (crad[i+1]),
      .rem_o       (crem[i+1]),
      .root_o      (croot[i+1])
    );
  end

  tri_rc_finish #(
    .NW (NW),
    .RW (RW)
  ) u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .size_i      (size_q),
    .in_valid_i  (cv[RW]),
    .in_ready_o  (crdy[RW]),
    .meta_i      (cm[RW]),
    .rem_i       (crem[RW]),
    .root_i      (croot[RW]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .row_o       (row_index_o),
    .col_o       (col_index_o),
    .oor_o       (out_of_range_o)
  );

  // An accepted index past the triangle must be flagged at the front stage.
  `TRI_RC_ASSERT_NEXT(a_front_oor, in_valid_i && !in_stall_o && !cfg_we_i && oor_d, fv_q && fm_q.oor)
  // A valid result lies in the upper triangle.
  `TRI_RC_ASSERT_NOW(a_upper, out_valid_o && !out_of_range_o, col_index_o >= row_index_o)
  // A valid row is below n.
  `TRI_RC_ASSERT_NOW(a_row_lt_n, out_valid_o && !out_of_range_o, row_index_o < OUT_W'(size_q))
  // A flagged result carries zero coordinates.
  `TRI_RC_ASSERT_NOW(a_oor_zero, out_valid_o && out_of_range_o, row_index_o == '0 && col_index_o == '0)

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for triangular_index_to_row_col_core.
// Depends on tri_rc_pkg and the core RTL; includes an in-bench unrank predictor
// and a small scoreboard class.
module testbench;
  import tri_rc_pkg::*;

  localparam int unsigned SIZE_BITS = 16;
  // Pipeline depth given by the core: SIZE_BITS capped at 16, plus six stages.
  localparam int unsigned PIPE_LAT = ((SIZE_BITS > 16) ? 16 : SIZE_BITS) + 6;
  // Worst case is roughly 900 items each with the longest gap, the longest stall
  // and a full pipeline trip, plus the drains between phases; take it ~4x.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 77;

  // One result item as the core presents it.
  typedef struct packed {
    logic [OUT_W-1:0] row;
    logic [OUT_W-1:0] col;
    logic             oor;
  } rc_result_t;

  // Holds the configured size and the queue of predicted results.
  class unrank_scoreboard;
    bit [CFG_W-1:0] size = 1;
    rc_result_t     expected_rc[$];
    int unsigned    mismatch_count = 0;

    function void set_size(bit [CFG_W-1:0] n);
      size = n;
    endfunction

    // Unrank a flat index with an exact integer square root.
    function rc_result_t unrank(bit [IDX_W-1:0] idx);
      bit [63:0]  n, total, a, s, r, trial, k, row, col;
      rc_result_t res;
      n = 64'(size) & ((64'd1 << SIZE_BITS) - 1);
      total = n * (n + 1) / 2;
      res = '0;
      if (64'(idx) >= total) begin
        res.oor = 1'b1;
        return res;
      end
      a = total - 64'(idx);
      s = 8 * a + 1;
      r = 0;
      // s stays below 2^35, so the root fits in 18 bits.
      for (int b = 20; b >= 0; b--) begin
        trial = r | (64'd1 << b);
        if (trial * trial <= s) r = trial;
      end
      k = (r * r == s) ? (r - 1) / 2 - 1 : (r - 1) / 2;
      row = n - k - 1;
      col = 64'(idx) + row * (row + 1) / 2 - n * row;
      res.row = row[OUT_W-1:0];
      res.col = col[OUT_W-1:0];
      return res;
    endfunction

    function void note_index(bit [IDX_W-1:0] idx);
      expected_rc.push_back(unrank(idx));
    endfunction

    function void check_result(rc_result_t got);
      rc_result_t want;
      if (expected_rc.size() == 0) begin
        $error("unexpected result: row %0d col %0d oor %0b", got.row, got.col, got.oor);
        mismatch_count++;
        return;
      end
      want = expected_rc.pop_front();
      if (got.row !== want.row) begin
        $error("row_index: expected %0d, got %0d", want.row, got.row);
        mismatch_count++;
      end
      if (got.col !== want.col) begin
        $error("col_index: expected %0d, got %0d", want.col, got.col);
        mismatch_count++;
      end
      if (got.oor !== want.oor) begin
        $error("out_of_range: expected %0b, got %0b", want.oor, got.oor);
        mismatch_count++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_rc.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [IDX_W-1:0] flat_index_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [OUT_W-1:0] row_index_o;
  logic [OUT_W-1:0] col_index_o;
  logic             out_of_range_o;

  // Calm flags switch off idling on one side for a whole phase.
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  unrank_scoreboard sb = new();

  triangular_index_to_row_col_core #(
    .SIZE_BITS(SIZE_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .flat_index_i  (flat_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .row_index_o   (row_index_o),
    .col_index_o   (col_index_o),
    .out_of_range_o(out_of_range_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: end the run if it never drains.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  // Track the size register exactly when the core latches it.
  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) sb.set_size(cfg_wdata_i);
  end

  // Predict on every accepted input item.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_index(flat_index_i);
  end

  // Check every accepted result item against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{row: row_index_o, col: col_index_o, oor: out_of_range_o});
  end

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Receiver: stall in random bursts unless the phase runs calm.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left == 0 && !rx_calm && $urandom_range(0, 99) < 25)
        stall_left = pick_gap();
      if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  function automatic bit [IDX_W-1:0] tri_total(bit [CFG_W-1:0] n);
    return IDX_W'((64'(n) * (64'(n) + 1)) / 2);
  endfunction

  // Draw an index: mostly in range, with row edges, the end of the triangle,
  // just past it, and raw 32-bit noise.
  function automatic bit [IDX_W-1:0] rand_index(bit [CFG_W-1:0] n);
    bit [IDX_W-1:0] total, r, pick;
    int unsigned    sel;
    total = tri_total(n);
    sel = $urandom_range(0, 99);
    if (total == 0 || sel >= 92) return $urandom();
    if (sel < 65) return $urandom_range(0, total - 1);
    if (sel < 75) return total - 1 - $urandom_range(0, (total - 1 < 8) ? total - 1 : 8);
    if (sel < 85) begin
      r = $urandom_range(0, n - 1);
      pick = r * n - r * (r - 1) / 2;
      if ($urandom_range(0, 1)) pick = pick + (n - r) - 1;
      return pick;
    end
    return total + $urandom_range(0, 8);
  endfunction

  // Present one item after a random gap and hold it until accepted.
  // Entered and left just after a rising edge.
  task automatic send_index(input bit [IDX_W-1:0] idx);
    int unsigned gap;
    gap = tx_calm ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    flat_index_i = idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // Write the size only while the core is empty.
  task automatic write_size(input bit [CFG_W-1:0] n);
    drain();
    repeat (PIPE_LAT + 4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = n;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    bit [CFG_W-1:0] sizes[11];
    bit [IDX_W-1:0] total;
    int unsigned    sel;

    // Drive every input to a known value before the first edge.
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    flat_index_i = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed: reset size of one, a single element.
    send_index(32'd0);
    send_index(32'd1);
    send_index(32'hFFFF_FFFF);

    // Size zero: nothing is in range.
    write_size(16'd0);
    send_index(32'd0);
    send_index(32'd1);
    send_index(32'h8000_0000);

    // Largest size: first and last elements, row boundaries, just past the end.
    write_size(16'hFFFF);
    total = tri_total(16'hFFFF);
    send_index(32'd0);
    send_index(32'd1);
    send_index(32'd65534);
    send_index(32'd65535);
    send_index(32'd65536);
    send_index(total - 3);
    send_index(total - 2);
    send_index(total - 1);
    send_index(total);
    send_index(total + 1);
    send_index(32'h5555_5555);
    send_index(32'hAAAA_AAAA);
    send_index(32'hFFFF_FFFF);

    // Size two: all three elements, then the first index past them.
    write_size(16'd2);
    send_index(32'd0);
    send_index(32'd1);
    send_index(32'd2);
    send_index(32'd3);

    // Random phases over a spread of sizes, extremes included.
    sizes = '{16'd1, 16'd2, 16'd3, 16'd7, 16'd64, 16'd255, 16'd1000,
              16'($urandom_range(1, 65535)), 16'd65534, 16'd65535,
              16'($urandom_range(2, 300))};
    foreach (sizes[p]) begin
      write_size(sizes[p]);
      // Run about one phase in four without idling on a side.
      sel = $urandom_range(0, 3);
      tx_calm = (sel == 0);
      rx_calm = (sel == 0) || (sel == 1 && $urandom_range(0, 1));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Hold off mid-phase once so the pipe empties with no config change.
        if (p == 4 && i == ITEMS_PER_PHASE / 2) drain();
        send_index(rand_index(sizes[p]));
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    drain();
    repeat (PIPE_LAT + 8) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ triangular_index_to_row_col_core.f @@
+incdir+rtl
rtl/tri_rc_pkg.sv
rtl/tri_rc_sqrt_cell.sv
rtl/tri_rc_finish.sv
rtl/triangular_index_to_row_col_core.sv
tb/sv/testbench.sv
